FILE: design/margp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mount axis planner package
// Shared constants, register addresses, command codes and the configuration
// and result structures of the mount axis rate and goto planner.
// ----------------------------------------------------------------------------
package margp_pkg;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 24;

  localparam logic [ADDR_W-1:0] REG_RA_STEPS   = 3'd0;
  localparam logic [ADDR_W-1:0] REG_DEC_STEPS  = 3'd1;
  localparam logic [ADDR_W-1:0] REG_RA_TIMER   = 3'd2;
  localparam logic [ADDR_W-1:0] REG_DEC_TIMER  = 3'd3;
  localparam logic [ADDR_W-1:0] REG_RA_FACTOR  = 3'd4;
  localparam logic [ADDR_W-1:0] REG_DEC_FACTOR = 3'd5;
  localparam logic [ADDR_W-1:0] REG_SOUTH      = 3'd6;

  localparam logic [1:0] CMD_CONFIG = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;
  localparam logic [1:0] CMD_GOTO   = 2'd2;

  localparam logic [1:0] GEAR_LOW  = 2'd0;
  localparam logic [1:0] GEAR_HIGH = 2'd1;
  localparam logic [1:0] GEAR_SLEW = 2'd2;

  localparam logic [23:0] STEPS_RESET  = 24'd9024000;
  localparam logic [23:0] TIMER_RESET  = 24'd64935;
  localparam logic [7:0]  FACTOR_RESET = 8'd16;

  localparam logic [23:0]  MAX24           = 24'hFFFFFF;
  localparam logic [23:0]  HOME_STEPS      = 24'h800000;
  localparam logic [23:0]  SLOW_MARGIN     = 24'd80000;
  localparam logic [20:0]  ARCSEC_PER_TURN = 21'd1296000;
  localparam logic [127:0] TURBO_NUM       = 128'd165888000000000000;
  localparam logic [127:0] SIDEREAL_DAY_NS = 128'd86164090530833;

  localparam int NUM_W   = 53;
  localparam int DEN_W   = 49;
  localparam int QUOT_W  = 24;
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 26;
  localparam int MUL_P_W = 59;

  typedef struct packed {
    logic [1:0][23:0] steps;
    logic [1:0][23:0] timer;
    logic [1:0][7:0]  factor;
    logic             south;
  } cfg_t;

  typedef struct packed {
    logic        accepted;
    logic        set_gearing;
    logic        reverse_dir;
    logic [1:0]  gearing_mode;
    logic [23:0] rate_code;
    logic        move_issued;
    logic [23:0] step_count;
    logic [23:0] slowdown_at;
  } result_t;

endpackage

FILE: design/margp_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mount axis planner channels
// Valid/ready channels for command items, result items and register writes.
// ----------------------------------------------------------------------------
interface margp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic               axis_sel;
  logic signed [24:0] target_rate;
  logic [23:0]        target_turn;
  logic [23:0]        present_steps;

  modport source (output valid, cmd, axis_sel, target_rate, target_turn, present_steps,
                  input ready);
  modport sink (input valid, cmd, axis_sel, target_rate, target_turn, present_steps,
                output ready);
endinterface

interface margp_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        set_gearing;
  logic        reverse_dir;
  logic [1:0]  gearing_mode;
  logic [23:0] rate_code;
  logic        move_issued;
  logic [23:0] step_count;
  logic [23:0] slowdown_at;

  modport source (output valid, accepted, set_gearing, reverse_dir, gearing_mode, rate_code,
                  move_issued, step_count, slowdown_at, input ready);
  modport sink (input valid, accepted, set_gearing, reverse_dir, gearing_mode, rate_code,
                move_issued, step_count, slowdown_at, output ready);
endinterface

interface margp_cfg_if;
  import margp_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

FILE: design/margp_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mount axis planner shared multiplier
// Signed multiplier with a registered product, time-shared by the sequencer.
// ----------------------------------------------------------------------------
module margp_mul (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [margp_pkg::MUL_A_W-1:0]  a,
  input  logic signed [margp_pkg::MUL_B_W-1:0]  b,
  output logic signed [margp_pkg::MUL_P_W-1:0]  p_r
);
  import margp_pkg::*;

  logic signed [MUL_P_W-1:0] p_nxt;

  assign p_nxt = a * b;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

endmodule

FILE: design/margp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mount axis planner divider
// Restoring shift-subtract divider, one quotient bit per cycle, with a
// saturating 24-bit quotient rounded half to even.
// ----------------------------------------------------------------------------
module margp_div #(
  parameter int NUM_W = 63
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [NUM_W-1:0]                    num,
  input  logic [margp_pkg::DEN_W-1:0]         den,
  output logic                                done_r,
  output logic [margp_pkg::QUOT_W-1:0]        quot_r
);
  import margp_pkg::*;

  localparam int HI_W  = NUM_W - QUOT_W;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
  localparam int REM_W = DEN_W + 1;
  localparam int CNT_W = $clog2(QUOT_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(QUOT_W - 1);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_ROUND} dstate_t;

  dstate_t             state_r;
  logic [DEN_W-1:0]    den_r;
  logic [REM_W-1:0]    rem_r;
  logic [QUOT_W-1:0]   lo_r;
  logic [QUOT_W-1:0]   q_r;
  logic [CNT_W-1:0]    cnt_r;

  logic [HI_W-1:0]     hi_c;
  logic                ovf_c;
  logic [REM_W-1:0]    rem_sh;
  logic                ge_c;
  logic [REM_W-1:0]    rem_sub;
  logic [REM_W:0]      twice_c;
  logic                up_c;

  assign hi_c    = num[NUM_W-1:QUOT_W];
  assign ovf_c   = (den == '0) || (CMP_W'(hi_c) >= CMP_W'(den));
  assign rem_sh  = {rem_r[DEN_W-1:0], lo_r[QUOT_W-1]};
  assign ge_c    = rem_sh >= REM_W'(den_r);
  assign rem_sub = rem_sh - REM_W'(den_r);
  assign twice_c = {rem_r, 1'b0};
  assign up_c    = (twice_c > (REM_W+1)'(den_r)) ||
                   ((twice_c == (REM_W+1)'(den_r)) && q_r[0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            if (ovf_c) begin
              quot_r <= MAX24;
              done_r <= 1'b1;
            end else begin
              den_r   <= den;
              rem_r   <= REM_W'(hi_c);
              lo_r    <= num[QUOT_W-1:0];
              q_r     <= '0;
              cnt_r   <= '0;
              state_r <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem_r <= ge_c ? rem_sub : rem_sh;
          q_r   <= {q_r[QUOT_W-2:0], ge_c};
          lo_r  <= {lo_r[QUOT_W-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST) begin
            state_r <= D_ROUND;
          end
        end
        D_ROUND: begin
          if (up_c && (q_r != MAX24)) begin
            quot_r <= q_r + 1'b1;
          end else begin
            quot_r <= q_r;
          end
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: begin
          state_r <= D_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/margp_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mount axis planner register file
// Holds the per-axis gearing, timer and site registers written over the
// configuration channel.
// ----------------------------------------------------------------------------
module margp_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  margp_cfg_if.sink         cfg_ch,
  output margp_pkg::cfg_t   cfg_r
);
  import margp_pkg::*;

  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.steps  <= {STEPS_RESET, STEPS_RESET};
      cfg_r.timer  <= {TIMER_RESET, TIMER_RESET};
      cfg_r.factor <= {FACTOR_RESET, FACTOR_RESET};
      cfg_r.south  <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        REG_RA_STEPS:   cfg_r.steps[0]  <= cfg_ch.data[23:0];
        REG_DEC_STEPS:  cfg_r.steps[1]  <= cfg_ch.data[23:0];
        REG_RA_TIMER:   cfg_r.timer[0]  <= cfg_ch.data[23:0];
        REG_DEC_TIMER:  cfg_r.timer[1]  <= cfg_ch.data[23:0];
        REG_RA_FACTOR:  cfg_r.factor[0] <= cfg_ch.data[7:0];
        REG_DEC_FACTOR: cfg_r.factor[1] <= cfg_ch.data[7:0];
        REG_SOUTH:      cfg_r.south     <= cfg_ch.data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: design/mount_axis_rate_and_goto_planner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mount axis rate and goto planner
// Sequencer that plans rate and goto commands for a two-axis mount using one
// shared multiplier and one iterative divider.
// ----------------------------------------------------------------------------
// The block works on one item at a time and drops in_ch.ready from
// acceptance until its result is stored in the output register. A rate
// command runs the 24 iterations of the shift-subtract divider that forms
// the rate code, unless the rate code saturates without dividing; a
// refused update stops before the divider, and a goto uses the multiplier
// and no divider. A finished result waits in the output register while the
// next item is accepted, and a result that finds that register still
// occupied holds the block until the waiting item is taken.
module mount_axis_rate_and_goto_planner_core #(
  parameter int POSITION_BITS  = 24,
  parameter int RATE_FRAC_BITS = 10
) (
  input  logic         clk,
  input  logic         rst_n,
  margp_in_if.sink     in_ch,
  margp_out_if.source  out_ch,
  margp_cfg_if.sink    cfg_ch
);
  import margp_pkg::*;

  localparam int SW        = POSITION_BITS + 34;
  localparam int QW        = SW - POSITION_BITS;
  localparam int DIV_NUM_W = NUM_W + RATE_FRAC_BITS;
  localparam logic [127:0] TURBO_THR = (TURBO_NUM << RATE_FRAC_BITS) / SIDEREAL_DAY_NS;
  localparam logic [33:0]  TURN_WRAP = 34'(3) << (POSITION_BITS - 2);
  localparam logic signed [33:0] TURN_SPAN = 34'(1) << POSITION_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_TURBO, S_NUM, S_DIV, S_WAIT,
    S_GSUM, S_GRND, S_GDELTA, S_GFIN, S_DONE
  } state_t;

  cfg_t cfg;

  state_t              state_r;
  logic [1:0]          cmd_r;
  logic                ax_r;
  logic signed [24:0]  rate_r;
  logic [23:0]         turn_r;
  logic [23:0]         present_r;
  logic [24:0]         m_r;
  logic                rev_r;
  logic                turbo_r;
  logic                change_r;
  logic [DEN_W-1:0]    den_r;
  logic signed [SW-1:0] s_r;
  logic [QW:0]         target_r;
  logic signed [QW+1:0] delta_r;
  result_t             res_r;
  result_t             out_r;
  logic                out_valid_r;
  logic [1:0]          cache_valid_r;
  logic [1:0]          cache_rev_r;
  logic [1:0]          cache_turbo_r;

  logic [23:0]          steps_c;
  logic [23:0]          timer_c;
  logic [7:0]           factor_c;
  logic signed [25:0]   rate_ext;
  logic signed [25:0]   rate_adj;
  logic                 rev_c;
  logic [24:0]          m_c;
  logic signed [33:0]   turn_ext;
  logic signed [33:0]   t_c;
  logic                 turbo_c;
  logic [7:0]           fac_c;
  logic                 change_c;
  logic                 mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p_r;
  logic [DIV_NUM_W-1:0] div_num;
  logic                 div_done;
  logic [QUOT_W-1:0]    div_quot;
  logic [23:0]          zero_c;
  logic signed [SW-1:0] zero_sh;
  logic signed [SW-1:0] s_c;
  logic [SW-1:0]        us_c;
  logic [QW-1:0]        q_c;
  logic [POSITION_BITS-1:0] r_c;
  logic                 up_c;
  logic [QW:0]          target_c;
  logic signed [QW+1:0] delta_c;
  logic [QW:0]          dist_c;
  logic [QW:0]          slow_c;
  logic [23:0]          dist_sat;
  logic [23:0]          slow_sat;

  margp_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg_r  (cfg)
  );

  assign steps_c  = cfg.steps[ax_r];
  assign timer_c  = cfg.timer[ax_r];
  assign factor_c = cfg.factor[ax_r];

  assign rate_ext = 26'(rate_r);
  assign rate_adj = (cfg.south && !ax_r) ? -rate_ext : rate_ext;
  assign rev_c    = rate_adj[25];
  assign m_c      = rev_c ? 25'(-rate_adj) : 25'(rate_adj);

  assign turn_ext = $signed(34'(turn_r));
  assign t_c      = (34'(turn_r) > TURN_WRAP) ? turn_ext - TURN_SPAN : turn_ext;

  assign turbo_c  = 128'(m_r) > TURBO_THR;
  assign fac_c    = !turbo_c ? 8'd1 : ((factor_c == '0) ? 8'd1 : factor_c);
  assign change_c = turbo_c || !cache_valid_r[ax_r] || (cache_rev_r[ax_r] != rev_r) ||
                    cache_turbo_r[ax_r];

  always_comb begin
    mul_en = 1'b1;
    unique case (state_r)
      S_PREP: begin
        mul_a = {9'b0, steps_c};
        mul_b = (cmd_r == CMD_GOTO) ? 26'(t_c) : {1'b0, m_c};
      end
      S_TURBO: begin
        mul_a = {9'b0, timer_c};
        mul_b = {18'b0, fac_c};
      end
      S_NUM: begin
        mul_a = {1'b0, mul_p_r[31:0]};
        mul_b = 26'(ARCSEC_PER_TURN);
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
  end

  margp_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p_r)
  );

  assign div_num = DIV_NUM_W'(mul_p_r[NUM_W-1:0]) << RATE_FRAC_BITS;

  margp_div #(
    .NUM_W (DIV_NUM_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_DIV),
    .num    (div_num),
    .den    (den_r),
    .done_r (div_done),
    .quot_r (div_quot)
  );

  assign zero_c   = HOME_STEPS - {2'b00, steps_c[23:2]};
  assign zero_sh  = SW'(zero_c) << POSITION_BITS;
  assign s_c      = zero_sh + SW'(mul_p_r);
  assign us_c     = s_r[SW-1] ? '0 : s_r;
  assign q_c      = us_c[SW-1:POSITION_BITS];
  assign r_c      = us_c[POSITION_BITS-1:0];
  assign up_c     = r_c[POSITION_BITS-1] && ((|r_c[POSITION_BITS-2:0]) || q_c[0]);
  assign target_c = {1'b0, q_c} + (QW+1)'(up_c);
  assign delta_c  = $signed({1'b0, target_r}) - $signed((QW+2)'(present_r));
  assign dist_c   = delta_r[QW+1] ? (QW+1)'(-delta_r) : (QW+1)'(delta_r);
  assign slow_c   = (dist_c >= (QW+1)'(SLOW_MARGIN)) ? dist_c - (QW+1)'(SLOW_MARGIN)
                                                     : dist_c >> 1;
  assign dist_sat = (dist_c > (QW+1)'(MAX24)) ? MAX24 : dist_c[23:0];
  assign slow_sat = (slow_c > (QW+1)'(MAX24)) ? MAX24 : slow_c[23:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      cache_valid_r <= '0;
      cache_rev_r   <= '0;
      cache_turbo_r <= '0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r     <= in_ch.cmd;
            ax_r      <= in_ch.axis_sel;
            rate_r    <= in_ch.target_rate;
            turn_r    <= in_ch.target_turn;
            present_r <= in_ch.present_steps;
            state_r   <= S_PREP;
          end
        end
        S_PREP: begin
          res_r <= '0;
          m_r   <= m_c;
          rev_r <= rev_c;
          unique case (cmd_r)
            CMD_CONFIG, CMD_UPDATE: state_r <= S_TURBO;
            CMD_GOTO:               state_r <= S_GSUM;
            default:                state_r <= S_DONE;
          endcase
        end
        S_TURBO: begin
          den_r    <= mul_p_r[DEN_W-1:0];
          turbo_r  <= turbo_c;
          change_r <= change_c;
          state_r  <= S_NUM;
        end
        S_NUM: begin
          if ((cmd_r == CMD_UPDATE) && change_r) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            res_r.accepted     <= 1'b1;
            res_r.set_gearing  <= (cmd_r == CMD_CONFIG) && change_r;
            res_r.reverse_dir  <= rev_r;
            res_r.gearing_mode <= turbo_r ? GEAR_HIGH : GEAR_LOW;
            res_r.rate_code    <= div_quot;
            cache_valid_r[ax_r] <= 1'b1;
            cache_rev_r[ax_r]   <= rev_r;
            cache_turbo_r[ax_r] <= turbo_r;
            state_r <= S_DONE;
          end
        end
        S_GSUM: begin
          s_r     <= s_c;
          state_r <= S_GRND;
        end
        S_GRND: begin
          target_r <= target_c;
          state_r  <= S_GDELTA;
        end
        S_GDELTA: begin
          delta_r <= delta_c;
          state_r <= S_GFIN;
        end
        S_GFIN: begin
          res_r.accepted <= 1'b1;
          if (delta_r != '0) begin
            res_r.set_gearing  <= 1'b1;
            res_r.reverse_dir  <= delta_r[QW+1];
            res_r.gearing_mode <= GEAR_SLEW;
            res_r.move_issued  <= 1'b1;
            res_r.step_count   <= dist_sat;
            res_r.slowdown_at  <= slow_sat;
            cache_valid_r[ax_r] <= 1'b0;
            cache_rev_r[ax_r]   <= delta_r[QW+1];
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE) && rst_n;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.accepted     = out_r.accepted;
  assign out_ch.set_gearing  = out_r.set_gearing;
  assign out_ch.reverse_dir  = out_r.reverse_dir;
  assign out_ch.gearing_mode = out_r.gearing_mode;
  assign out_ch.rate_code    = out_r.rate_code;
  assign out_ch.move_issued  = out_r.move_issued;
  assign out_ch.step_count   = out_r.step_count;
  assign out_ch.slowdown_at  = out_r.slowdown_at;

endmodule

FILE: design/margp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mount axis planner checker
// Port-level assertions on the planner's channel behavior, bound to the top.
// ----------------------------------------------------------------------------
module margp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [77:0] out_data
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready right after an item was taken");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without the planner having been busy");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

endmodule

bind mount_axis_rate_and_goto_planner_core margp_checker u_margp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  ({out_ch.accepted, out_ch.set_gearing, out_ch.reverse_dir, out_ch.gearing_mode,
               out_ch.rate_code, out_ch.move_issued, out_ch.step_count, out_ch.slowdown_at})
);

FILE: test/mount_axis_rate_and_goto_planner_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mount axis planner testbench
// Drives rate, update and goto commands into the planner and programs its
// registers between phases. Every accepted command is run through a local
// model of the per-axis gearing state. The expected item is queued and
// checked against the next item that leaves the planner. Both channels idle
// at random, and the output side is held off for a long stretch.
// ----------------------------------------------------------------------------
module mount_axis_rate_and_goto_planner_core_tb;
  import margp_pkg::*;

  localparam int POS_BITS    = 24;
  localparam int RATE_FRAC   = 10;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  margp_in_if  in_ch ();
  margp_out_if out_ch ();
  margp_cfg_if cfg_ch ();

  mount_axis_rate_and_goto_planner_core #(
    .POSITION_BITS (POS_BITS),
    .RATE_FRAC_BITS(RATE_FRAC)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  logic [23:0] steps_cfg [2];
  logic [23:0] timer_cfg [2];
  logic [7:0]  factor_cfg [2];
  logic        south_cfg;
  logic        gear_valid [2];
  logic        gear_rev [2];
  logic        gear_turbo [2];

  result_t expected_plans [$];
  int      mismatches;
  int      items_sent;
  int      turbo_edge;
  int      hold_request;
  bit      idle_on;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint goto_target(logic [23:0] total, logic [23:0] turn);
    longint frac, sum, whole, part, half;
    frac = longint'(turn);
    if (frac > (longint'(3) <<< (POS_BITS - 2))) frac -= longint'(1) <<< POS_BITS;
    sum = (longint'(HOME_STEPS) - longint'(total / 4)) * (longint'(1) <<< POS_BITS)
          + frac * longint'(total);
    if (sum < 0) sum = 0;
    whole = sum >>> POS_BITS;
    part = sum & ((longint'(1) <<< POS_BITS) - 1);
    half = longint'(1) <<< (POS_BITS - 1);
    if (part > half || (part == half && whole[0])) whole++;
    return whole;
  endfunction

  function automatic result_t plan_command(logic [1:0] cmd, logic ax,
                                           logic signed [24:0] rate_in,
                                           logic [23:0] turn, logic [23:0] present);
    result_t      res;
    int           rate;
    logic [127:0] mag, num, den, quo, rem;
    logic [23:0]  code;
    logic         rev, turbo, change;
    longint       delta, travel, slow;
    res = '0;
    case (cmd)
      CMD_CONFIG, CMD_UPDATE: begin
        rate = int'(rate_in);
        if (south_cfg && !ax) rate = -rate;
        rev = rate < 0;
        mag = 128'(rev ? -rate : rate);
        turbo = (mag * SIDEREAL_DAY_NS) > (TURBO_NUM << RATE_FRAC);
        num = 128'(timer_cfg[ax]) *
              ((turbo && factor_cfg[ax] != 0) ? factor_cfg[ax] : 8'd1);
        num = (num * ARCSEC_PER_TURN) << RATE_FRAC;
        den = mag * steps_cfg[ax];
        if (den == 0) begin
          code = MAX24;
        end else begin
          quo = num / den;
          rem = num % den;
          if (2 * rem > den || (2 * rem == den && quo[0])) quo++;
          code = (quo > MAX24) ? MAX24 : quo[23:0];
        end
        change = turbo || !gear_valid[ax] || gear_rev[ax] != rev || gear_turbo[ax];
        if (!(cmd == CMD_UPDATE && change)) begin
          res.accepted = 1'b1;
          res.set_gearing = (cmd == CMD_CONFIG) && change;
          res.reverse_dir = rev;
          res.gearing_mode = turbo ? GEAR_HIGH : GEAR_LOW;
          res.rate_code = code;
          gear_valid[ax] = 1'b1;
          gear_rev[ax] = rev;
          gear_turbo[ax] = turbo;
        end
      end
      CMD_GOTO: begin
        res.accepted = 1'b1;
        delta = goto_target(steps_cfg[ax], turn) - longint'(present);
        if (delta != 0) begin
          rev = delta < 0;
          travel = rev ? -delta : delta;
          slow = (travel >= longint'(SLOW_MARGIN)) ? travel - longint'(SLOW_MARGIN)
                                                   : travel / 2;
          res.set_gearing = 1'b1;
          res.reverse_dir = rev;
          res.gearing_mode = GEAR_SLEW;
          res.move_issued = 1'b1;
          res.step_count = (travel > longint'(MAX24)) ? MAX24 : travel[23:0];
          res.slowdown_at = (slow > longint'(MAX24)) ? MAX24 : slow[23:0];
          gear_valid[ax] = 1'b0;
          gear_rev[ax] = rev;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : scoreboard
    result_t got, want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.accepted, out_ch.set_gearing, out_ch.reverse_dir, out_ch.gearing_mode,
               out_ch.rate_code, out_ch.move_issued, out_ch.step_count, out_ch.slowdown_at};
        if (expected_plans.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected item from the planner: %h", $realtime, got);
        end else begin
          want = expected_plans.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: planner item mismatch", $realtime);
              $display("  expected acc=%0b gear=%0b rev=%0b mode=%0d code=%h move=%0b cnt=%h slow=%h",
                       want.accepted, want.set_gearing, want.reverse_dir, want.gearing_mode,
                       want.rate_code, want.move_issued, want.step_count, want.slowdown_at);
              $display("  actual   acc=%0b gear=%0b rev=%0b mode=%0d code=%h move=%0b cnt=%h slow=%h",
                       got.accepted, got.set_gearing, got.reverse_dir, got.gearing_mode,
                       got.rate_code, got.move_issued, got.step_count, got.slowdown_at);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_plans.push_back(plan_command(in_ch.cmd, in_ch.axis_sel, in_ch.target_rate,
                                              in_ch.target_turn, in_ch.present_steps));
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          REG_RA_STEPS:   steps_cfg[0] = cfg_ch.data;
          REG_DEC_STEPS:  steps_cfg[1] = cfg_ch.data;
          REG_RA_TIMER:   timer_cfg[0] = cfg_ch.data;
          REG_DEC_TIMER:  timer_cfg[1] = cfg_ch.data;
          REG_RA_FACTOR:  factor_cfg[0] = cfg_ch.data[7:0];
          REG_DEC_FACTOR: factor_cfg[1] = cfg_ch.data[7:0];
          REG_SOUTH:      south_cfg = cfg_ch.data[0];
          default: ;
        endcase
      end
    end
  end

  initial begin : result_sink
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_request != 0) begin
        out_ch.ready <= 1'b0;
        n = hold_request;
        hold_request = 0;
        repeat (n - 1) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("mount_axis_rate_and_goto_planner_core_tb: errors");
    $finish;
  end

  task automatic send_cmd(logic [1:0] cmd, logic ax, logic signed [24:0] rate,
                          logic [23:0] turn, logic [23:0] present);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.axis_sel <= ax;
    in_ch.target_rate <= rate;
    in_ch.target_turn <= turn;
    in_ch.present_steps <= present;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_rate(logic [1:0] cmd, logic ax, bit neg, int mag);
    logic signed [24:0] rate;
    rate = neg ? 25'(-mag) : 25'(mag);
    send_cmd(cmd, ax, rate, 24'($urandom), 24'($urandom));
  endtask

  function automatic int pick_mag(bit slow_only);
    case ($urandom_range(0, slow_only ? 3 : 7))
      0: return $urandom_range(0, 64);
      1: return $urandom_range(1, 30000);
      2: return turbo_edge - $urandom_range(0, 4);
      3: return $urandom_range(1, turbo_edge);
      4: return turbo_edge + $urandom_range(1, 4);
      5: return $urandom_range(turbo_edge + 1, 24'hFFFFFF);
      6: return $urandom_range(0, 1) ? 32'h1000000 : 32'hFFFFFF;
      default: return $urandom_range(0, 32'h1000000);
    endcase
  endfunction

  function automatic logic [23:0] present_near(logic ax, logic [23:0] turn, longint off);
    longint p;
    p = goto_target(steps_cfg[ax], turn) + off;
    if (p < 0) p = 0;
    else if (p > longint'(MAX24)) p = longint'(MAX24);
    return p[23:0];
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_plans.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic program_registers(logic [23:0] ra_steps, logic [23:0] dec_steps,
                                   logic [23:0] ra_timer, logic [23:0] dec_timer,
                                   logic [23:0] ra_fac, logic [23:0] dec_fac,
                                   logic [23:0] south);
    logic [ADDR_W-1:0] idx [7];
    logic [23:0]       val [7];
    idx = '{REG_RA_STEPS, REG_DEC_STEPS, REG_RA_TIMER, REG_DEC_TIMER,
            REG_RA_FACTOR, REG_DEC_FACTOR, REG_SOUTH};
    val = '{ra_steps, dec_steps, ra_timer, dec_timer, ra_fac, dec_fac, south};
    drain();
    for (int i = 0; i < 7; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.addr <= idx[i];
      cfg_ch.data <= val[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_goto();
    logic        ax;
    logic [23:0] turn, present;
    ax = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 4))
        0: turn = 24'h000000;
        1: turn = 24'hFFFFFF;
        2: turn = 24'hC00000;
        3: turn = 24'hC00001;
        default: turn = 24'h400000;
      endcase
    end else begin
      turn = 24'($urandom);
    end
    case ($urandom_range(0, 4))
      0: present = present_near(ax, turn, 0);
      1: present = present_near(ax, turn, ($urandom_range(0, 1) ? -1 : 1) *
                                longint'($urandom_range(1, 79999)));
      2: present = present_near(ax, turn, ($urandom_range(0, 1) ? -1 : 1) *
                                longint'($urandom_range(80000, 400000)));
      3: present = 24'($urandom);
      default: present = $urandom_range(0, 1) ? MAX24 : 24'd0;
    endcase
    send_cmd(CMD_GOTO, ax, 25'($urandom), turn, present);
  endtask

  task automatic rate_run();
    logic ax;
    bit   neg;
    ax = 1'($urandom_range(0, 1));
    neg = 1'($urandom_range(0, 1));
    send_rate(CMD_CONFIG, ax, neg, pick_mag($urandom_range(0, 3) != 0));
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 4) != 0)
        send_rate(CMD_UPDATE, ax, neg, pick_mag(1));
      else
        send_rate($urandom_range(0, 1) ? CMD_UPDATE : CMD_CONFIG, ax,
                  1'($urandom_range(0, 1)), pick_mag(0));
    end
  endtask

  task automatic random_traffic(int count);
    int stop;
    logic ax;
    stop = items_sent + count;
    while (items_sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: rate_run();
        4, 5, 6: random_goto();
        7: send_rate(CMD_UPDATE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     pick_mag(0));
        8: begin
          ax = 1'($urandom_range(0, 1));
          send_cmd(CMD_GOTO, ax, 25'($urandom), 24'($urandom), 24'($urandom));
          send_rate(CMD_UPDATE, ax, 1'($urandom_range(0, 1)), pick_mag(1));
        end
        default: send_cmd(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 25'($urandom),
                          24'($urandom), 24'($urandom));
      endcase
    end
  endtask

  task automatic test_rate_gearing();
    send_rate(CMD_UPDATE, 1'b0, 1'b0, 15400);
    send_rate(CMD_CONFIG, 1'b0, 1'b0, 15400);
    send_rate(CMD_UPDATE, 1'b0, 1'b0, 16000);
    send_rate(CMD_UPDATE, 1'b0, 1'b1, 16000);
    send_rate(CMD_CONFIG, 1'b0, 1'b1, 16000);
    send_rate(CMD_CONFIG, 1'b0, 1'b0, turbo_edge);
    send_rate(CMD_CONFIG, 1'b0, 1'b0, turbo_edge + 1);
    send_rate(CMD_UPDATE, 1'b0, 1'b0, 1000);
    send_rate(CMD_CONFIG, 1'b1, 1'b0, 0);
    send_rate(CMD_CONFIG, 1'b1, 1'b0, 24'hFFFFFF);
    send_rate(CMD_CONFIG, 1'b1, 1'b1, 32'h1000000);
    send_rate(CMD_UPDATE, 1'b1, 1'b0, 5);
    send_cmd(CMD_UNUSED, 1'b1, 25'h1FFFFFF, MAX24, MAX24);
  endtask

  task automatic test_goto_positions();
    send_cmd(CMD_GOTO, 1'b0, '0, 24'h000000, present_near(1'b0, 24'h000000, 0));
    send_cmd(CMD_GOTO, 1'b0, '0, 24'hC00000, 24'd0);
    send_cmd(CMD_GOTO, 1'b0, '0, 24'hC00001, MAX24);
    send_cmd(CMD_GOTO, 1'b1, '0, 24'h400000, present_near(1'b1, 24'h400000, -1000));
    send_cmd(CMD_GOTO, 1'b1, '0, 24'hFFFFFF, 24'd0);
    send_cmd(CMD_GOTO, 1'b1, '0, 24'h7FFFFF, present_near(1'b1, 24'h7FFFFF, 100000));
    send_rate(CMD_UPDATE, 1'b1, 1'b0, 15400);
    send_rate(CMD_CONFIG, 1'b0, 1'b0, 15400);
    send_rate(CMD_UPDATE, 1'b0, 1'b0, 15400);
  endtask

  task automatic test_default_traffic();
    random_traffic(240);
  endtask

  task automatic test_register_extremes();
    program_registers(24'd1, MAX24, MAX24, 24'd1, 24'd255, 24'd1, 24'd1);
    send_rate(CMD_CONFIG, 1'b0, 1'b0, 15400);
    send_rate(CMD_UPDATE, 1'b0, 1'b1, 15400);
    random_traffic(90);
    program_registers(MAX24, 24'd1, 24'd1, MAX24, 24'd1, 24'd255, 24'd0);
    send_cmd(CMD_GOTO, 1'b0, '0, 24'hC00000, 24'd0);
    send_cmd(CMD_GOTO, 1'b0, '0, 24'hC00001, MAX24);
    random_traffic(90);
  endtask

  task automatic test_zero_registers();
    program_registers(24'd0, 24'd0, 24'd0, 24'd0, 24'hFFFF00, 24'h000100, 24'hFFFFFE);
    send_rate(CMD_CONFIG, 1'b0, 1'b0, turbo_edge + 1);
    send_rate(CMD_CONFIG, 1'b1, 1'b1, 15400);
    random_traffic(60);
  endtask

  task automatic test_output_backpressure();
    program_registers(24'($urandom_range(1, MAX24)), 24'($urandom_range(1, MAX24)),
                      24'($urandom_range(1, MAX24)), 24'($urandom_range(1, MAX24)),
                      24'($urandom), 24'($urandom), 24'($urandom));
    hold_request = LONG_HOLD;
    random_traffic(60);
  endtask

  task automatic test_sender_pause();
    program_registers(24'($urandom_range(1, MAX24)), 24'($urandom),
                      24'($urandom_range(1, 200000)), 24'($urandom),
                      24'($urandom_range(1, 255)), 24'($urandom_range(1, 255)), 24'd1);
    random_traffic(40);
    drain();
    random_traffic(40);
  endtask

  task automatic test_steady_stream();
    program_registers(STEPS_RESET, STEPS_RESET, TIMER_RESET, TIMER_RESET,
                      24'(FACTOR_RESET), 24'(FACTOR_RESET), 24'd1);
    idle_on = 1'b0;
    random_traffic(150);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_CONFIG;
    in_ch.axis_sel = 1'b0;
    in_ch.target_rate = '0;
    in_ch.target_turn = '0;
    in_ch.present_steps = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = REG_RA_STEPS;
    cfg_ch.data = '0;
    for (int a = 0; a < 2; a++) begin
      steps_cfg[a] = STEPS_RESET;
      timer_cfg[a] = TIMER_RESET;
      factor_cfg[a] = FACTOR_RESET;
      gear_valid[a] = 1'b0;
      gear_rev[a] = 1'b0;
      gear_turbo[a] = 1'b0;
    end
    south_cfg = 1'b0;
    mismatches = 0;
    items_sent = 0;
    hold_request = 0;
    idle_on = 1'b1;
    turbo_edge = int'((TURBO_NUM << RATE_FRAC) / SIDEREAL_DAY_NS);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_rate_gearing();
    test_goto_positions();
    test_default_traffic();
    test_register_extremes();
    test_zero_registers();
    test_output_backpressure();
    test_sender_pause();
    test_steady_stream();

    drain();
    if (mismatches == 0) begin
      $display("mount_axis_rate_and_goto_planner_core_tb: clean");
    end else begin
      $display("mount_axis_rate_and_goto_planner_core_tb: errors");
    end
    $finish;
  end

endmodule
